>>> rtl/pwbt_pkg.sv
`default_nettype none

package pwbt_pkg;

    // Transmit sequencer phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_START = 3'd2;
    localparam logic [2:0] PH_GAP1  = 3'd3;
    localparam logic [2:0] PH_GAP2  = 3'd4;
    localparam logic [2:0] PH_ACT1  = 3'd5;
    localparam logic [2:0] PH_ACT2  = 3'd6;
    localparam logic [2:0] PH_STOP  = 3'd7;

    // Configuration register indexes
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_IDLE_LIMIT     = 3'd0;
    localparam cfg_index_t REG_ZERO_THRESHOLD = 3'd1;
    localparam cfg_index_t REG_BIT_PERIOD     = 3'd2;
    localparam cfg_index_t REG_CLEAR_TO_SEND  = 3'd3;
    localparam cfg_index_t REG_RX_INVERTED    = 3'd4;
    localparam cfg_index_t REG_TX_INVERTED    = 3'd5;

    // Register reset values
    localparam int unsigned RST_IDLE_LIMIT     = 400;
    localparam int unsigned RST_ZERO_THRESHOLD = 150;
    localparam int unsigned RST_BIT_PERIOD     = 100;
    localparam int unsigned RST_CLEAR_TO_SEND  = 2000;

endpackage

`default_nettype wire

>>> rtl/pulse_width_bus_transceiver.sv
`default_nettype none
// Pulse-width coded serial bus transceiver, one request per time-base tick.
// Input channel (s_): each request is one tick: the sampled bus level, and in
// s_tuser a flag that asks to send s_tdata's word. Output channel (m_): one
// result per request: transmit pin level, busy flag, a received word with its
// valid flag, and a flag for a send request dropped because the sender was busy.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce. An index
// beyond the register list is ignored. The result of a request is registered and
// presented on m_ in the cycle after the request is accepted. Throughput: one request
// per cycle when not stalled; all work for a request is one pass of logic from the
// accepted request and the receiver and transmitter state into the result register.
// A stalled receiver (m_tready low) holds the result register; s_tready stays
// high while the result register is empty or is being taken this cycle.
// Reset (aresetn low, synchronous) empties the result register, restores the
// register defaults, sets the line history to idle with a saturated gap
// counter and puts the transmitter back to idle.
module pulse_width_bus_transceiver
    import pwbt_pkg::*;
#(
    parameter int WORD_BITS  = 16,
    parameter int TIMER_BITS = 20
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // configuration write port
    input  wire                                  cfg_wr_en,
    input  wire  [2:0]                           cfg_index,
    input  wire  [TIMER_BITS-1:0]                cfg_wdata,
    // request channel
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [((1 + WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // bus_level, send_word
    input  wire                                  s_tuser,   // kind
    // result channel
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [((4 + WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata   // tx_line, tx_busy,
                                                  // word_valid, rx_word, request_dropped
);

    localparam int OUT_W   = ((4 + WORD_BITS + 7) / 8) * 8;
    localparam int BITS_W  = $clog2(WORD_BITS + 1);
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [BITS_W-1:0]     WORD_CNT  = BITS_W'(WORD_BITS);

    // configuration registers
    logic [TIMER_BITS-1:0] idle_limit_reg, zero_threshold_reg;
    logic [TIMER_BITS-1:0] bit_period_reg, clear_to_send_reg;
    logic                  rx_inverted_reg, tx_inverted_reg;

    // receiver / transmitter state
    logic                  last_level_reg;
    logic [TIMER_BITS-1:0] gap_count_reg, gap_count_next;
    logic [WORD_BITS-1:0]  rx_shift_reg, rx_shift_next;
    logic [BITS_W-1:0]     rx_bits_reg, rx_bits_next;
    logic [2:0]            tx_phase_reg, tx_phase_next;
    logic [TIMER_BITS-1:0] tx_timer_reg, tx_timer_next;
    logic [WORD_BITS-1:0]  tx_shift_reg, tx_shift_next;
    logic [BITS_W-1:0]     tx_bits_reg, tx_bits_next;

    // result register
    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_data_reg, m_data_next;

    logic                  accept;
    logic                  kind, level;
    logic [WORD_BITS-1:0]  send_word;
    logic                  active, take_req, dropped, receiving, level_edge;
    logic [2:0]            cur_phase;
    logic [TIMER_BITS-1:0] gap, timer_cur, timer_inc, wait_timer;
    logic [WORD_BITS-1:0]  shift_cur, rx_shifted;
    logic [BITS_W-1:0]     bits_cur, rx_bits_inc, tx_bits_inc;
    logic                  seg_done, tx_msb, drive_active, word_valid;
    logic [WORD_BITS-1:0]  rx_word;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign kind      = s_tuser;
    assign level     = s_tdata[0];
    assign send_word = s_tdata[WORD_BITS:1];

    // request intake and current phase
    assign active    = level != ~rx_inverted_reg;
    assign take_req  = kind && (tx_phase_reg == PH_IDLE);
    assign dropped   = kind && (tx_phase_reg != PH_IDLE);
    assign cur_phase = take_req ? PH_WAIT : tx_phase_reg;
    assign shift_cur = take_req ? send_word : tx_shift_reg;
    assign bits_cur  = take_req ? '0 : tx_bits_reg;
    assign timer_cur = take_req ? '0 : tx_timer_reg;
    assign receiving = (cur_phase == PH_IDLE) || (cur_phase == PH_WAIT);

    // receiver: gap timing and bit decode
    assign gap         = (gap_count_reg == TIMER_MAX) ? TIMER_MAX : gap_count_reg + 1'b1;
    assign level_edge  = (level != last_level_reg) && receiving;
    assign rx_shifted  = {rx_shift_reg[WORD_BITS-2:0], gap > zero_threshold_reg};
    assign rx_bits_inc = rx_bits_reg + 1'b1;

    always_comb begin
        rx_shift_next  = rx_shift_reg;
        rx_bits_next   = rx_bits_reg;
        word_valid     = 1'b0;
        rx_word        = '0;
        gap_count_next = level_edge ? '0 : gap;
        if (level_edge && active) begin
            if (gap > idle_limit_reg) begin
                rx_shift_next = '0;
                rx_bits_next  = '0;
            end else if (rx_bits_inc == WORD_CNT) begin
                word_valid    = 1'b1;
                rx_word       = rx_shifted;
                rx_shift_next = '0;
                rx_bits_next  = '0;
            end else begin
                rx_shift_next = rx_shifted;
                rx_bits_next  = rx_bits_inc;
            end
        end
    end

    // transmitter sequencer
    assign timer_inc   = (timer_cur == TIMER_MAX) ? TIMER_MAX : timer_cur + 1'b1;
    assign seg_done    = (timer_inc >= bit_period_reg) || (timer_inc == TIMER_MAX);
    assign tx_msb      = shift_cur[WORD_BITS-1];
    assign tx_bits_inc = bits_cur + 1'b1;
    assign wait_timer  = active ? '0 : timer_inc;

    always_comb begin
        tx_phase_next = cur_phase;
        tx_timer_next = timer_cur;
        tx_shift_next = shift_cur;
        tx_bits_next  = bits_cur;
        drive_active  = 1'b0;
        case (cur_phase)
            PH_WAIT: begin
                if (wait_timer >= clear_to_send_reg) begin
                    tx_timer_next = '0;
                    tx_phase_next = PH_START;
                end else begin
                    tx_timer_next = wait_timer;
                end
            end
            PH_START, PH_GAP1, PH_GAP2, PH_ACT1, PH_ACT2, PH_STOP: begin
                drive_active  = (cur_phase == PH_START) || (cur_phase == PH_ACT1) ||
                                (cur_phase == PH_ACT2);
                tx_timer_next = seg_done ? '0 : timer_inc;
                if (seg_done) begin
                    case (cur_phase)
                        PH_START: tx_phase_next = PH_GAP1;
                        PH_GAP1:  tx_phase_next = tx_msb ? PH_GAP2 : PH_ACT1;
                        PH_GAP2:  tx_phase_next = PH_ACT1;
                        PH_STOP:  tx_phase_next = PH_IDLE;
                        default: begin
                            // active part of a data bit
                            if (cur_phase == PH_ACT1 && !tx_msb) begin
                                tx_phase_next = PH_ACT2;
                            end else begin
                                tx_shift_next = {shift_cur[WORD_BITS-2:0], 1'b0};
                                tx_bits_next  = tx_bits_inc;
                                tx_phase_next = (tx_bits_inc >= WORD_CNT) ? PH_STOP
                                                                          : PH_GAP1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // result packing
    always_comb begin
        m_data_next                  = '0;
        m_data_next[0]               = ~drive_active ^ tx_inverted_reg;
        m_data_next[1]               = cur_phase != PH_IDLE;
        m_data_next[2]               = word_valid;
        m_data_next[WORD_BITS+2:3]   = rx_word;
        m_data_next[WORD_BITS+3]     = dropped;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg     <= TIMER_BITS'(RST_IDLE_LIMIT);
            zero_threshold_reg <= TIMER_BITS'(RST_ZERO_THRESHOLD);
            bit_period_reg     <= TIMER_BITS'(RST_BIT_PERIOD);
            clear_to_send_reg  <= TIMER_BITS'(RST_CLEAR_TO_SEND);
            rx_inverted_reg    <= 1'b0;
            tx_inverted_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IDLE_LIMIT:     idle_limit_reg     <= cfg_wdata;
                REG_ZERO_THRESHOLD: zero_threshold_reg <= cfg_wdata;
                REG_BIT_PERIOD:     bit_period_reg     <= cfg_wdata;
                REG_CLEAR_TO_SEND:  clear_to_send_reg  <= cfg_wdata;
                REG_RX_INVERTED:    rx_inverted_reg    <= cfg_wdata[0];
                REG_TX_INVERTED:    tx_inverted_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // state update on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg <= 1'b1;
            gap_count_reg  <= TIMER_MAX;
            rx_shift_reg   <= '0;
            rx_bits_reg    <= '0;
            tx_phase_reg   <= PH_IDLE;
            tx_timer_reg   <= '0;
            tx_shift_reg   <= '0;
            tx_bits_reg    <= '0;
        end else if (accept) begin
            last_level_reg <= level;
            gap_count_reg  <= gap_count_next;
            rx_shift_reg   <= rx_shift_next;
            rx_bits_reg    <= rx_bits_next;
            tx_phase_reg   <= tx_phase_next;
            tx_timer_reg   <= tx_timer_next;
            tx_shift_reg   <= tx_shift_next;
            tx_bits_reg    <= tx_bits_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire
